// ===== hw/rtl/vlmr_pkg.sv =====
// shared types, constants and helpers for the variable-length message ring
// no dependencies

package vlmr_pkg;

    localparam int CFG_W    = 15;
    localparam int LEN_W    = 15;
    localparam int PTR_W    = 15;
    localparam int BYTE_W   = 8;
    localparam int STAT_W   = 2;
    localparam int HELD_W   = 14;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;
    localparam int CFG_MAX  = (1 << CFG_W) - 1;
    localparam int CAP_MIN  = 2;

    localparam int STORE_BYTES_DEF = 16384;
    localparam int CAP_RESET       = 16384;
    localparam int RESERVE_RESET   = 1024;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_RESERVE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_NO_MSG  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_MOVE,
        ACT_COMMIT
    } act_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_ACT,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic act;
        logic report;
    } dp_cmd_t;

    typedef struct packed {
        logic act_none;
    } dp_stat_t;

    typedef struct packed {
        logic [CFG_W-1:0] cap;
        logic             res_en;
        logic [CFG_W-1:0] res_lim;
        logic             cap_wr;
        logic [CFG_W-1:0] cap_new;
    } cfg_t;

    function automatic logic [CFG_W-1:0] clamp_cap(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v < CFG_W'(CAP_MIN))
        begin
            r = CFG_W'(CAP_MIN);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/vlmr_regs.sv =====
// apb configuration registers: capacity and reserve size, clamped views
// depends on vlmr_pkg

module vlmr_regs #(
    parameter int STORE_BYTES = vlmr_pkg::STORE_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vlmr_pkg::APB_AW-1:0] paddr,
    input  logic [vlmr_pkg::APB_DW-1:0] pwdata,
    output logic [vlmr_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output vlmr_pkg::cfg_t              cfg
);
    import vlmr_pkg::*;

    localparam logic [CFG_W-1:0] CAP_MAX =
        CFG_W'((STORE_BYTES > CFG_MAX) ? CFG_MAX : STORE_BYTES);

    logic [CFG_W-1:0] cap_raw_reg;
    logic [CFG_W-1:0] cap_raw_next;
    logic [CFG_W-1:0] res_reg;
    logic [CFG_W-1:0] res_next;
    logic             wr_en;
    logic             idx;

    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[APB_AW-1];
    assign pready = 1'b1;

    always_comb
    begin
        cap_raw_next = cap_raw_reg;
        res_next     = res_reg;
        if (wr_en)
        begin
            case (idx)
                REG_CAPACITY: cap_raw_next = pwdata[CFG_W-1:0];
                REG_RESERVE:  res_next     = pwdata[CFG_W-1:0];
                default:      cap_raw_next = cap_raw_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_raw_reg <= CFG_W'(CAP_RESET);
            res_reg     <= CFG_W'(RESERVE_RESET);
        end
        else
        begin
            cap_raw_reg <= cap_raw_next;
            res_reg     <= res_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_CAPACITY: prdata = APB_DW'(cap_raw_reg);
            REG_RESERVE:  prdata = APB_DW'(res_reg);
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.cap     = clamp_cap(cap_raw_reg, CAP_MAX);
        cfg.res_en  = (res_reg <= cfg.cap);
        cfg.res_lim = cfg.cap - res_reg;
        cfg.cap_wr  = wr_en && (idx == REG_CAPACITY);
        cfg.cap_new = clamp_cap(pwdata[CFG_W-1:0], CAP_MAX);
    end

endmodule

// ===== hw/rtl/vlmr_ctrl.sv =====
// sequencer for one transaction: load, decide, byte access, report
// depends on vlmr_pkg

module vlmr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  vlmr_pkg::dp_stat_t  stat,
    output vlmr_pkg::dp_cmd_t   cmd
);
    import vlmr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.act_none ? S_REPORT : S_ACT;
            end
            S_ACT:
            begin
                cmd.act    = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_decide_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DECIDE))
        else $error("load not followed by decide");
    a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> !busy)
        else $error("busy after report");
    a_no_start_taken_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && start) |-> !cmd.load)
        else $error("transaction loaded while busy");
`endif

endmodule

// ===== hw/rtl/vlmr_dp.sv =====
// datapath: byte store, ring pointers, message tracking, result registers
// depends on vlmr_pkg

module vlmr_dp #(
    parameter int STORE_BYTES = vlmr_pkg::STORE_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vlmr_pkg::dp_cmd_t           cmd,
    output vlmr_pkg::dp_stat_t          stat,
    input  vlmr_pkg::cfg_t              cfg,
    input  logic                        opcode,
    input  logic                        first_byte,
    input  logic [vlmr_pkg::LEN_W-1:0]  msg_length,
    input  logic [vlmr_pkg::BYTE_W-1:0] wr_byte,
    output logic                        out_valid,
    output logic [vlmr_pkg::STAT_W-1:0] status,
    output logic [vlmr_pkg::BYTE_W-1:0] rd_byte,
    output logic                        msg_done,
    output logic [vlmr_pkg::CFG_W-1:0]  free_space,
    output logic [vlmr_pkg::HELD_W-1:0] data_held,
    output logic                        readable,
    output logic                        writeable
);
    import vlmr_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam logic [CFG_W-1:0] CAP_MAX =
        CFG_W'((STORE_BYTES > CFG_MAX) ? CFG_MAX : STORE_BYTES);
    localparam logic [CFG_W-1:0] CAP_RST = clamp_cap(CFG_W'(CAP_RESET), CAP_MAX);

    logic [BYTE_W-1:0] mem [STORE_BYTES];
    logic [BYTE_W-1:0] mem_q;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;

    logic              in_op_reg,   in_op_next;
    logic              in_fb_reg,   in_fb_next;
    logic [LEN_W-1:0]  in_len_reg,  in_len_next;
    logic [BYTE_W-1:0] in_byte_reg, in_byte_next;

    logic [PTR_W-1:0]  wp_reg,      wp_next;
    logic [PTR_W-1:0]  rp_reg,      rp_next;
    logic              mode_reg,    mode_next;
    logic              open_reg,    open_next;
    logic              opc_reg,     opc_next;
    logic              refused_reg, refused_next;
    logic [PTR_W-1:0]  cursor_reg,  cursor_next;
    logic [LEN_W-1:0]  rem_reg,     rem_next;
    act_t              act_reg,     act_next;
    status_t           stat_reg,    stat_next;
    logic              done_reg,    done_next;
    logic              rdsel_reg,   rdsel_next;
    logic [CFG_W-1:0]  fs_reg,      fs_next;
    logic [PTR_W-1:0]  dh_reg,      dh_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [BYTE_W-1:0] out_rd_reg,     out_rd_next;
    logic              out_done_reg,   out_done_next;
    logic [CFG_W-1:0]  out_fs_reg,     out_fs_next;
    logic [HELD_W-1:0] out_dh_reg,     out_dh_next;
    logic              out_rdable_reg, out_rdable_next;
    logic              out_wrable_reg, out_wrable_next;

    logic [PTR_W-1:0]  avail;
    logic              fits;
    logic [PTR_W-1:0]  start_ptr;
    logic [PTR_W:0]    end_sum;
    logic              wrap;
    logic [PTR_W-1:0]  start_adj;
    logic              match;
    act_t              dec_act;
    logic [PTR_W-1:0]  cursor_inc;
    logic [PTR_W-1:0]  commit_val;
    logic [PTR_W-1:0]  commit_ptr;
    logic              do_commit;
    logic [CFG_W-1:0]  fs_calc;
    logic [PTR_W:0]    dh_sum;
    logic [PTR_W-1:0]  dh_calc;

    // first byte checks, start position and action decision
    always_comb
    begin
        avail     = in_op_reg ? dh_reg : fs_reg;
        fits      = (avail >= in_len_reg);
        start_ptr = in_op_reg ? rp_reg : wp_reg;
        end_sum   = {1'b0, start_ptr} + {1'b0, in_len_reg};
        wrap      = (end_sum >= {1'b0, cfg.cap})
                    || (cfg.res_en && (start_ptr >= cfg.res_lim));
        start_adj = wrap ? '0 : start_ptr;
        match     = open_reg && (in_op_reg == opc_reg);
        if (in_fb_reg)
        begin
            if (!fits)
            begin
                dec_act = ACT_NONE;
            end
            else if (in_len_reg == '0)
            begin
                dec_act = ACT_COMMIT;
            end
            else
            begin
                dec_act = ACT_MOVE;
            end
        end
        else if (!match || refused_reg)
        begin
            dec_act = ACT_NONE;
        end
        else
        begin
            dec_act = ACT_MOVE;
        end
        stat.act_none = (dec_act == ACT_NONE);
    end

    // commit and ring occupancy
    always_comb
    begin
        cursor_inc = cursor_reg + PTR_W'(1);
        commit_val = (act_reg == ACT_MOVE) ? cursor_inc : cursor_reg;
        commit_ptr = (commit_val == cfg.cap) ? '0 : commit_val;
        do_commit  = (act_reg == ACT_COMMIT)
                     || ((act_reg == ACT_MOVE) && (rem_reg == LEN_W'(1)));
        fs_calc    = (wp_reg >= rp_reg) ? (cfg.cap - wp_reg + rp_reg) : (rp_reg - wp_reg);
        dh_sum     = {1'b0, wp_reg} + {1'b0, cfg.cap} - {1'b0, rp_reg};
        dh_calc    = (dh_sum >= {1'b0, cfg.cap}) ? PTR_W'(dh_sum - {1'b0, cfg.cap})
                                                 : PTR_W'(dh_sum);
    end

    assign mem_we   = cmd.act && (act_reg == ACT_MOVE) && !opc_reg;
    assign mem_re   = cmd.act && (act_reg == ACT_MOVE) && opc_reg;
    assign mem_addr = ADDR_W'(cursor_reg);

    always_comb
    begin
        in_op_next   = in_op_reg;
        in_fb_next   = in_fb_reg;
        in_len_next  = in_len_reg;
        in_byte_next = in_byte_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        mode_next    = mode_reg;
        open_next    = open_reg;
        opc_next     = opc_reg;
        refused_next = refused_reg;
        cursor_next  = cursor_reg;
        rem_next     = rem_reg;
        act_next     = act_reg;
        stat_next    = stat_reg;
        done_next    = done_reg;
        rdsel_next   = rdsel_reg;
        fs_next      = fs_reg;
        dh_next      = dh_reg;

        if (cmd.load)
        begin
            in_op_next   = opcode;
            in_fb_next   = first_byte;
            in_len_next  = msg_length;
            in_byte_next = wr_byte;
        end

        if (cmd.decide)
        begin
            act_next   = dec_act;
            done_next  = 1'b0;
            rdsel_next = 1'b0;
            stat_next  = ST_DONE;
            if (in_fb_reg)
            begin
                open_next = 1'b1;
                opc_next  = in_op_reg;
                if (fits)
                begin
                    refused_next = 1'b0;
                    cursor_next  = start_adj;
                    rem_next     = in_len_reg;
                end
                else
                begin
                    refused_next = 1'b1;
                    stat_next    = ST_REFUSED;
                    rem_next     = in_len_reg - LEN_W'(1);
                    open_next    = (in_len_reg != LEN_W'(1));
                end
            end
            else if (!match)
            begin
                stat_next = ST_NO_MSG;
            end
            else if (refused_reg)
            begin
                stat_next = ST_REFUSED;
                rem_next  = rem_reg - LEN_W'(1);
                open_next = (rem_reg != LEN_W'(1));
            end
        end

        if (cmd.act)
        begin
            if (act_reg == ACT_MOVE)
            begin
                cursor_next = cursor_inc;
                rem_next    = rem_reg - LEN_W'(1);
                rdsel_next  = opc_reg;
            end
            if (do_commit)
            begin
                if (!opc_reg)
                begin
                    wp_next   = commit_ptr;
                    mode_next = 1'b1;
                end
                else
                begin
                    rp_next   = commit_ptr;
                    mode_next = 1'b0;
                end
                open_next = 1'b0;
                done_next = 1'b1;
            end
        end

        if (cmd.report)
        begin
            fs_next = fs_calc;
            dh_next = dh_calc;
        end

        if (cfg.cap_wr)
        begin
            wp_next   = '0;
            rp_next   = '0;
            mode_next = 1'b0;
            open_next = 1'b0;
            fs_next   = cfg.cap_new;
            dh_next   = '0;
        end
    end

    always_comb
    begin
        out_valid_next  = cmd.report;
        out_status_next = out_status_reg;
        out_rd_next     = out_rd_reg;
        out_done_next   = out_done_reg;
        out_fs_next     = out_fs_reg;
        out_dh_next     = out_dh_reg;
        out_rdable_next = out_rdable_reg;
        out_wrable_next = out_wrable_reg;
        if (cmd.report)
        begin
            out_status_next = stat_reg;
            out_rd_next     = rdsel_reg ? mem_q : '0;
            out_done_next   = done_reg;
            out_fs_next     = fs_calc;
            out_dh_next     = dh_calc[HELD_W-1:0];
            out_rdable_next = mode_reg && (dh_calc != '0);
            out_wrable_next = !mode_reg && (fs_calc != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            mode_reg      <= 1'b0;
            open_reg      <= 1'b0;
            opc_reg       <= 1'b0;
            refused_reg   <= 1'b0;
            cursor_reg    <= '0;
            rem_reg       <= '0;
            act_reg       <= ACT_NONE;
            stat_reg      <= ST_DONE;
            done_reg      <= 1'b0;
            rdsel_reg     <= 1'b0;
            fs_reg        <= CAP_RST;
            dh_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            mode_reg      <= mode_next;
            open_reg      <= open_next;
            opc_reg       <= opc_next;
            refused_reg   <= refused_next;
            cursor_reg    <= cursor_next;
            rem_reg       <= rem_next;
            act_reg       <= act_next;
            stat_reg      <= stat_next;
            done_reg      <= done_next;
            rdsel_reg     <= rdsel_next;
            fs_reg        <= fs_next;
            dh_reg        <= dh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_op_reg      <= in_op_next;
        in_fb_reg      <= in_fb_next;
        in_len_reg     <= in_len_next;
        in_byte_reg    <= in_byte_next;
        out_status_reg <= out_status_next;
        out_rd_reg     <= out_rd_next;
        out_done_reg   <= out_done_next;
        out_fs_reg     <= out_fs_next;
        out_dh_reg     <= out_dh_next;
        out_rdable_reg <= out_rdable_next;
        out_wrable_reg <= out_wrable_next;
    end

    // byte store, one access per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= in_byte_reg;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign rd_byte    = out_rd_reg;
    assign msg_done   = out_done_reg;
    assign free_space = out_fs_reg;
    assign data_held  = out_dh_reg;
    assign readable   = out_rdable_reg;
    assign writeable  = out_wrable_reg;

`ifndef SYNTHESIS
    a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg < cfg.cap)
        else $error("write pointer beyond capacity");
    a_rp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg < cfg.cap)
        else $error("read pointer beyond capacity");
    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> (out_status_reg == ST_DONE))
        else $error("commit reported with error status");
    a_refused_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg && refused_reg) |-> (rem_reg != '0))
        else $error("refused message open with nothing left");
`endif

endmodule

// ===== hw/rtl/variable_length_message_ring_core.sv =====
// top level of the variable-length message ring
// depends on vlmr_pkg, vlmr_regs, vlmr_ctrl, vlmr_dp
//
// usage
// - command channel: drive opcode, first_byte, msg_length and wr_byte with
//   start high; the transaction is taken at an edge where busy is low
// - a transaction moves at most one message byte; first_byte opens a message
//   and checks its length against free space (write) or held data (read)
// - one result per transaction, shown for one cycle with out_valid high;
//   the receiver cannot stall, so results must be sampled when shown
// - out_valid rises after the decide, act and report states, the act state
//   only when a byte moves or a message commits; busy stays high until then
// - the core takes no new transaction until the previous one has been reported
// - apb port: capacity at address 0, reserve size at address 4; pready is
//   always high; writing capacity empties the ring and drops an open message
// - reset: pointers zero, ring writeable, no open message, capacity 16384,
//   reserve 1024; store contents are undefined until written

module variable_length_message_ring_core #(
    parameter int STORE_BYTES = vlmr_pkg::STORE_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic                        first_byte,
    input  logic [vlmr_pkg::LEN_W-1:0]  msg_length,
    input  logic [vlmr_pkg::BYTE_W-1:0] wr_byte,
    output logic                        out_valid,
    output logic [vlmr_pkg::STAT_W-1:0] status,
    output logic [vlmr_pkg::BYTE_W-1:0] rd_byte,
    output logic                        msg_done,
    output logic [vlmr_pkg::CFG_W-1:0]  free_space,
    output logic [vlmr_pkg::HELD_W-1:0] data_held,
    output logic                        readable,
    output logic                        writeable,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vlmr_pkg::APB_AW-1:0] paddr,
    input  logic [vlmr_pkg::APB_DW-1:0] pwdata,
    output logic [vlmr_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import vlmr_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    vlmr_regs #(
        .STORE_BYTES(STORE_BYTES)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vlmr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    vlmr_dp #(
        .STORE_BYTES(STORE_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg        (cfg),
        .opcode     (opcode),
        .first_byte (first_byte),
        .msg_length (msg_length),
        .wr_byte    (wr_byte),
        .out_valid  (out_valid),
        .status     (status),
        .rd_byte    (rd_byte),
        .msg_done   (msg_done),
        .free_space (free_space),
        .data_held  (data_held),
        .readable   (readable),
        .writeable  (writeable)
    );

endmodule
